// ===== design/ita_pkg.sv =====
// Shared types and constants of the integer-to-ASCII formatter.
// No dependencies; every other design file imports this package.
package ita_pkg;

    localparam int VALUE_W    = 64;
    localparam int MAX_DIGITS = 20;
    localparam int DIGIT_W    = 4;
    localparam int DIGITS_W   = MAX_DIGITS * DIGIT_W;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int ITER_W     = $clog2(VALUE_W);
    localparam int CHAR_W     = 8;

    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_X    = 8'h78;  // 'x'
    localparam logic [CHAR_W-1:0] CH_A    = 8'h41;  // 'A'

    // Format select codes on the op field
    localparam logic OP_HEX = 1'b0;
    localparam logic OP_DEC = 1'b1;

    // Source of an emitted character
    localparam logic [1:0] SEL_PFX_ZERO = 2'd0;
    localparam logic [1:0] SEL_PFX_X    = 2'd1;
    localparam logic [1:0] SEL_DIGIT    = 2'd2;

    typedef struct packed {
        logic       load;     // capture op and value
        logic       dabble;   // one shift-add-3 step
        logic       shift;    // drop the top digit
        logic       emit;     // load the output word
        logic [1:0] emit_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic conv_last;  // final conversion step in progress
        logic top_zero;   // top digit is zero
        logic rem_one;    // one digit left
        logic hex;        // hexadecimal run
        logic nonzero;    // value was not zero
        logic out_free;   // output register can take a word
    } t_dp_status;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10)) begin
            c = CH_ZERO + CHAR_W'(d);
        end else begin
            c = CH_A + CHAR_W'(d - DIGIT_W'(10));
        end
        return c;
    endfunction

endpackage

// ===== design/ita_if.sv =====
// Valid/ready channel interfaces for the formatter's input and output words.
// Depends on ita_pkg for field widths.
interface ita_in_if import ita_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               op;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface ita_out_if import ita_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== design/ita_datapath.sv =====
// Datapath: binary register, BCD/hex digit register, counters and output word register.
// Depends on ita_pkg; driven by ita_controller through t_dp_cmd.
module ita_datapath import ita_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic               i_op,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_out_ready,
    output t_dp_status         o_status,
    output logic               o_out_valid,
    output logic [CHAR_W-1:0]  o_out_char,
    output logic               o_out_last
);

    logic [VALUE_W-1:0]  r_bin,       n_bin;
    logic [DIGITS_W-1:0] r_digits,    n_digits;
    logic [ITER_W-1:0]   r_iter,      n_iter;
    logic [CNT_W-1:0]    r_rem,       n_rem;
    logic                r_hex,       n_hex;
    logic                r_nonzero,   n_nonzero;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_char,  n_out_char;
    logic                r_out_last,  n_out_last;

    logic [DIGITS_W-1:0] adj;
    logic [DIGIT_W-1:0]  top_digit;
    logic                rem_one;

    assign top_digit = r_digits[DIGITS_W-1 -: DIGIT_W];
    assign rem_one   = (r_rem == CNT_W'(1));

    // Add 3 to every BCD digit of five or more
    always_comb begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (r_digits[k*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                adj[k*DIGIT_W +: DIGIT_W] = r_digits[k*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                adj[k*DIGIT_W +: DIGIT_W] = r_digits[k*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb begin
        n_bin       = r_bin;
        n_digits    = r_digits;
        n_iter      = r_iter;
        n_rem       = r_rem;
        n_hex       = r_hex;
        n_nonzero   = r_nonzero;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        if (i_cmd.load) begin
            n_bin     = i_value;
            n_iter    = '0;
            n_rem     = CNT_W'(MAX_DIGITS);
            n_hex     = (i_op == OP_HEX);
            n_nonzero = (i_value != '0);
            if (i_op == OP_HEX) begin
                n_digits = {{(DIGITS_W - VALUE_W){1'b0}}, i_value};
            end else begin
                n_digits = '0;
            end
        end else if (i_cmd.dabble) begin
            n_digits = {adj[DIGITS_W-2:0], r_bin[VALUE_W-1]};
            n_bin    = {r_bin[VALUE_W-2:0], 1'b0};
            n_iter   = r_iter + ITER_W'(1);
        end else if (i_cmd.shift) begin
            n_digits = {r_digits[DIGITS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            n_rem    = r_rem - CNT_W'(1);
        end

        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            case (i_cmd.emit_sel)
                SEL_PFX_ZERO: begin
                    n_out_char = CH_ZERO;
                    n_out_last = 1'b0;
                end
                SEL_PFX_X: begin
                    n_out_char = CH_X;
                    n_out_last = 1'b0;
                end
                SEL_DIGIT: begin
                    n_out_char = digit_char(top_digit);
                    n_out_last = rem_one;
                end
                default: begin
                    n_out_char = CH_ZERO;
                    n_out_last = 1'b0;
                end
            endcase
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_bin      <= n_bin;
        r_digits   <= n_digits;
        r_iter     <= n_iter;
        r_rem      <= n_rem;
        r_hex      <= n_hex;
        r_nonzero  <= n_nonzero;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_status.conv_last = &r_iter;
    assign o_status.top_zero  = (top_digit == '0);
    assign o_status.rem_one   = rem_one;
    assign o_status.hex       = r_hex;
    assign o_status.nonzero   = r_nonzero;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

// ===== design/ita_controller.sv =====
// Controller state machine: sequences load, conversion, zero skip and character emission.
// Depends on ita_pkg; commands ita_datapath through t_dp_cmd.
module ita_controller import ita_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_op,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_SKIP  = 3'd2;
    localparam logic [2:0] S_PFX0  = 3'd3;
    localparam logic [2:0] S_PFXX  = 3'd4;
    localparam logic [2:0] S_DIGIT = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_in_op == OP_HEX) ? S_SKIP : S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.dabble = 1'b1;
                if (i_status.conv_last) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (i_status.top_zero && !i_status.rem_one) begin
                    o_cmd.shift = 1'b1;
                end else if (i_status.hex && i_status.nonzero) begin
                    n_state = S_PFX0;
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_PFX0: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = SEL_PFX_ZERO;
                    n_state        = S_PFXX;
                end
            end
            S_PFXX: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = SEL_PFX_X;
                    n_state        = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = SEL_DIGIT;
                    o_cmd.shift    = 1'b1;
                    if (i_status.rem_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/integer_to_ascii_formatter.sv =====
// Top level of the integer-to-ASCII formatter: controller plus datapath.
// Depends on ita_pkg, ita_in_if/ita_out_if, ita_controller and ita_datapath.
//
// Formats a 64-bit unsigned value as ASCII text, one character per output
// word, most significant digit first with no leading zeros. op = 0 gives
// hexadecimal with a "0x" prefix and upper-case A-F; op = 1 gives decimal.
// Zero always yields the single word '0' (no prefix). The last word of each
// value carries last = 1. Input words are taken one at a time: after an
// accept the block is busy until the value's final character has been
// loaded into the output register, and then it takes the next word while
// that character still waits. Steps per value: one load step; in decimal
// mode 64 shift-add-3 steps of the BCD converter follow; then one step per
// leading zero digit dropped (the digit register holds 20 digits, so up to
// 19), one decision step, and one step per emitted character (up to 18 in
// hex, 20 in decimal). Dropped zeros plus digits always fill the 20-digit
// register. The output register emits one character per cycle while the
// sink takes every word at once.
module integer_to_ascii_formatter import ita_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ita_in_if.sink   i_in,
    ita_out_if.source o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;

    ita_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .i_status   (status),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    ita_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_op        (i_in.op),
        .i_value     (i_in.value),
        .i_out_ready (o_out.ready),
        .o_status    (status),
        .o_out_valid (o_out.valid),
        .o_out_char  (o_out.char_code),
        .o_out_last  (o_out.last)
    );

    // Not ready in the cycle after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("formatter ready right after an accept");

    // Only the final character of a value may wait while a new word can enter
    a_idle_holds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.ready && o_out.valid) |-> o_out.last)
        else $error("formatter idle with an unfinished run pending");

    // Never overwrite a word the sink has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> status.out_free)
        else $error("output word overwritten before it was taken");

    // A prefix character is never flagged as last
    a_prefix_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && (cmd.emit_sel == SEL_PFX_ZERO || cmd.emit_sel == SEL_PFX_X))
            |=> !o_out.last)
        else $error("prefix character flagged as last");

endmodule

// ===== dv/integer_to_ascii_formatter_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of integer_to_ascii_formatter: drives values in hex and decimal
// mode and checks every emitted character against an internal text predictor.
// Depends on ita_pkg, ita_in_if/ita_out_if and the integer_to_ascii_formatter RTL.
module integer_to_ascii_formatter_tb;
    import ita_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } ascii_char_t;

    // Holds the characters still owed by the block, oldest first, and counts failures.
    class ascii_text_tracker;
        ascii_char_t owed[$];
        int          fails;

        function new();
            fails = 0;
        endfunction

        // Spell one accepted value and queue its characters.
        function void note_value(logic op, logic [VALUE_W-1:0] value);
            logic [DIGIT_W-1:0] digs[MAX_DIGITS];
            logic [VALUE_W-1:0] rest;
            logic [VALUE_W-1:0] radix;
            logic [CHAR_W-1:0]  glyph;
            int                 count;
            if (value == '0) begin
                // zero is a lone '0' in either mode: no prefix
                owed.push_back('{code: CH_ZERO, last: 1'b1});
                return;
            end
            radix = (op == OP_DEC) ? VALUE_W'(10) : VALUE_W'(16);
            rest  = value;
            count = 0;
            while (rest != '0 && count < MAX_DIGITS) begin
                digs[count] = DIGIT_W'(rest % radix);
                rest        = rest / radix;
                count++;
            end
            if (op == OP_HEX) begin
                owed.push_back('{code: CH_ZERO, last: 1'b0});
                owed.push_back('{code: CH_X, last: 1'b0});
            end
            for (int i = count - 1; i >= 0; i--) begin
                if (digs[i] < DIGIT_W'(10)) glyph = CH_ZERO + CHAR_W'(digs[i]);
                else                        glyph = CH_A + CHAR_W'(digs[i] - DIGIT_W'(10));
                owed.push_back('{code: glyph, last: (i == 0)});
            end
        endfunction

        // Compare one accepted output word with the oldest owed character.
        function void check_char(logic [CHAR_W-1:0] code, logic last);
            ascii_char_t want;
            if (owed.size() == 0) begin
                $error("unexpected word: char_code %h last %b", code, last);
                fails++;
                return;
            end
            want = owed.pop_front();
            if (code !== want.code) begin
                $error("char_code: expected %h, actual %h", want.code, code);
                fails++;
            end
            if (last !== want.last) begin
                $error("last: expected %b, actual %b", want.last, last);
                fails++;
            end
        endfunction

        function bit drained();
            return owed.size() == 0;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ita_in_if  in_ch ();
    ita_out_if out_ch ();

    integer_to_ascii_formatter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ascii_text_tracker text_board = new();

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run of every value in decimal
    // mode with the longest stalls on both sides.
    initial begin
        #6_000_000;
        $display("integer_to_ascii_formatter: mismatch");
        $finish;
    end

    // Present one value. Called at a falling edge; returns at the falling
    // edge after the accept, with valid still high so the next call can keep
    // it up without a dip.
    task automatic send_value(input logic op, input logic [VALUE_W-1:0] value);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.value <= value;
        // Sample at the rising edge: the word moves when valid and ready are high.
        do @(posedge i_clk); while (!in_ch.ready);
        text_board.note_value(op, value);
        @(negedge i_clk);
    endtask

    // Hold the sender until every owed character has come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (!text_board.drained()) @(negedge i_clk);
    endtask

    // Output side: take words forever, with a fresh random stall per word.
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            text_board.check_char(out_ch.char_code, out_ch.last);
            @(negedge i_clk);
        end
    end

    // Main sequence: reset, directed values, random values, drain, verdict.
    initial begin
        logic [VALUE_W-1:0] val;
        logic [VALUE_W-1:0] pow;
        logic               op;
        int                 kind;
        int                 len;

        in_ch.valid = 1'b0;
        in_ch.op    = OP_HEX;
        in_ch.value = '0;
        i_rst_n     = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero in both modes, the extremes, digit boundaries, every hex glyph.
        send_value(OP_HEX, '0);
        send_value(OP_DEC, '0);
        send_value(OP_HEX, 64'd1);
        send_value(OP_DEC, 64'd1);
        send_value(OP_HEX, '1);
        send_value(OP_DEC, '1);
        send_value(OP_DEC, 64'd9);
        send_value(OP_DEC, 64'd10);
        send_value(OP_HEX, 64'hF);
        send_value(OP_HEX, 64'h10);
        send_value(OP_HEX, 64'h0123_4567_89AB_CDEF);
        send_value(OP_HEX, 64'hFEDC_BA98_7654_3210);
        send_value(OP_DEC, 64'd10_000_000_000_000_000_000);
        send_value(OP_DEC, 64'd9_999_999_999_999_999_999);
        send_value(OP_HEX, 64'h8000_0000_0000_0000);
        send_value(OP_DEC, 64'h8000_0000_0000_0000);
        send_value(OP_HEX, 64'h0000_0000_8000_0000);
        send_value(OP_DEC, 64'd99_999);
        send_value(OP_DEC, 64'd1_234_567_890);
        send_value(OP_HEX, 64'hA);

        // Pause the sender until the block has emitted everything owed.
        wait_drained();

        for (int n = 0; n < 400; n++) begin
            if (n % 97 == 50) wait_drained();
            op   = 1'($urandom_range(0, 1));
            kind = $urandom_range(0, 5);
            case (kind)
                0, 1: begin
                    val = {$urandom, $urandom};
                end
                2: begin
                    // random length so every digit count shows up
                    len = $urandom_range(1, VALUE_W);
                    val = {$urandom, $urandom} & (VALUE_W'('1) >> (VALUE_W - len));
                end
                3: begin
                    val = VALUE_W'($urandom_range(0, 20));
                end
                4: begin
                    // powers of ten and sixteen, and their neighbors
                    pow = 64'd1;
                    len = $urandom_range(0, 19);
                    if (op == OP_DEC) begin
                        repeat (len) pow = pow * 64'd10;
                    end else begin
                        pow = pow << (4 * (len % 16));
                    end
                    val = pow + VALUE_W'($urandom_range(0, 2)) - 64'd1;
                end
                default: begin
                    // wide values near the top of the range
                    val = '1 - VALUE_W'($urandom_range(0, 1000));
                end
            endcase
            send_value(op, val);
        end

        wait_drained();
        // Let any stray word show up before the verdict.
        repeat (200) @(negedge i_clk);

        if (text_board.fails == 0 && text_board.drained()) begin
            $display("integer_to_ascii_formatter: match");
        end else begin
            $display("integer_to_ascii_formatter: mismatch");
        end
        $finish;
    end

endmodule
